[hdl/cclm_pkg.sv]
// ----------------------------------------------------------------------------
// cclm_pkg
// Shared widths, sizes and interface types of the cluster cache LRU map.
// ----------------------------------------------------------------------------
package cclm_pkg;

	localparam int NUM_BLOCKS   = 16;
	localparam int NUM_CLUSTERS = 1024;

	localparam int BLK_W   = 4;                  // block index
	localparam int CNT_W   = 5;                  // holds 0 .. NUM_BLOCKS
	localparam int CLU_W   = 10;                 // cluster index
	localparam int STAMP_W = 32;                 // last-use stamp
	localparam int MAP_W   = BLK_W + 1;          // {cached, block}

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(NUM_BLOCKS);

	// Write into the block table: owner is written only on a bind
	typedef struct packed {
		logic               en;
		logic               owner_en;
		logic [BLK_W-1:0]   idx;
		logic [CLU_W-1:0]   owner;
		logic [STAMP_W-1:0] stamp;
	} bt_wr_t;

	typedef struct packed {
		logic [CLU_W-1:0]   owner;
		logic [STAMP_W-1:0] stamp;
	} bt_rd_t;

	typedef struct packed {
		logic             found;
		logic [BLK_W-1:0] idx;
	} bt_free_t;

endpackage

[hdl/cclm_block_table.sv]
// ----------------------------------------------------------------------------
// cclm_block_table
// Per-block owner and stamp memories with registered read, in-use flags and
// lowest free block search over the usable blocks.
// ----------------------------------------------------------------------------
module cclm_block_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cclm_pkg::bt_wr_t           wr,
	input  logic [cclm_pkg::BLK_W-1:0] rd_idx,
	output cclm_pkg::bt_rd_t           rd_data,
	input  logic [cclm_pkg::CNT_W-1:0] usable,
	output cclm_pkg::bt_free_t         free
);
	import cclm_pkg::*;

	logic [CLU_W-1:0]   owner_mem [NUM_BLOCKS];
	logic [STAMP_W-1:0] stamp_mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] used_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			stamp_mem[wr.idx] <= wr.stamp;
			if (wr.owner_en) begin
				owner_mem[wr.idx] <= wr.owner;
			end
		end
		rd_data.owner <= owner_mem[rd_idx];
		rd_data.stamp <= stamp_mem[rd_idx];
	end

	// A block once bound stays in use; an eviction rebinds it to the new cluster
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wr.en && wr.owner_en) begin
			used_q[wr.idx] <= 1'b1;
		end
	end

	// Lowest free block below the usable count: scan down so the lowest wins
	always_comb begin
		free = '0;
		for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
			if (!used_q[i] && (CNT_W'(i) < usable)) begin
				free.found = 1'b1;
				free.idx   = BLK_W'(i);
			end
		end
	end

endmodule

[hdl/cluster_cache_lru_map.sv]
// ----------------------------------------------------------------------------
// cluster_cache_lru_map
// Fully associative cluster cache with least-recently-used replacement by
// access stamps; maps each requested cluster to a cache block.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata[9:0] cluster_number
// m_*      out  m_tvalid/m_tready  tdata[3:0] block_number, [4] was_miss,
//                                  [5] evicted_valid, [15:6] evicted_cluster
// cfg_*    in   cfg_we             cfg_wdata[4:0] blocks_in_use
//
// A hit or a miss with a free block goes through a map memory read, then the
// update. A miss with all usable blocks taken reads the block table once per
// usable block to find the oldest stamp, then clears the evicted map entry and
// binds the block. After reset all 1024 map entries are cleared; no request is
// taken meanwhile. A stalled result holds the final update; the next request
// is taken while a result waits.
// ----------------------------------------------------------------------------
module cluster_cache_lru_map (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cclm_pkg::IN_DATA_W-1:0]  s_tdata,   // [9:0] cluster_number
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cclm_pkg::OUT_DATA_W-1:0] m_tdata,   // [3:0] block_number,
	                                                   // [4] was_miss,
	                                                   // [5] evicted_valid,
	                                                   // [15:6] evicted_cluster
	input  logic                            cfg_we,
	input  logic [cclm_pkg::CNT_W-1:0]      cfg_wdata
);
	import cclm_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_EVICT,
		ST_BIND
	} state_t;

	state_t             state_q;
	logic [CLU_W-1:0]   clr_q;
	logic [CNT_W-1:0]   cfg_q;
	logic [CLU_W-1:0]   cluster_q;
	logic [STAMP_W-1:0] count_q;
	logic [CNT_W-1:0]   scan_q;
	logic               cmp_valid_q;
	logic [BLK_W-1:0]   cmp_idx_q;
	logic [BLK_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [CLU_W-1:0]   best_owner_q;
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [MAP_W-1:0] map_mem [NUM_CLUSTERS];
	logic [MAP_W-1:0] map_rd_q;
	logic             map_we;
	logic [CLU_W-1:0] map_waddr;
	logic [MAP_W-1:0] map_wdata;

	logic [CNT_W-1:0] usable;
	logic [BLK_W-1:0] last_idx;
	logic             out_free;
	logic             accept;
	logic             hit;
	logic             take_best;
	bt_wr_t           bt_wr;
	bt_rd_t           bt_rd;
	bt_free_t         bt_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign hit      = map_rd_q[BLK_W];

	always_comb begin
		if (cfg_q == '0) begin
			usable = CNT_W'(1);
		end else if (cfg_q > CNT_W'(NUM_BLOCKS)) begin
			usable = CNT_W'(NUM_BLOCKS);
		end else begin
			usable = cfg_q;
		end
	end
	assign last_idx = BLK_W'(usable - CNT_W'(1));

	assign take_best = !cmp_valid_q || (bt_rd.stamp < best_stamp_q) ||
		(cmp_idx_q == '0);

	cclm_block_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (bt_wr),
		.rd_idx  (scan_q[BLK_W-1:0]),
		.rd_data (bt_rd),
		.usable  (usable),
		.free    (bt_free)
	);

	// Memory write requests for the current state
	always_comb begin
		map_we    = 1'b0;
		map_waddr = cluster_q;
		map_wdata = '0;
		bt_wr     = '0;
		bt_wr.owner = cluster_q;
		bt_wr.stamp = count_q;
		case (state_q)
			ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
			end
			ST_LOOKUP: begin
				if (out_free) begin
					if (hit) begin
						bt_wr.en  = 1'b1;
						bt_wr.idx = map_rd_q[BLK_W-1:0];
					end else if (bt_free.found) begin
						map_we         = 1'b1;
						map_wdata      = {1'b1, bt_free.idx};
						bt_wr.en       = 1'b1;
						bt_wr.owner_en = 1'b1;
						bt_wr.idx      = bt_free.idx;
					end
				end
			end
			ST_EVICT: begin
				map_we    = 1'b1;
				map_waddr = best_owner_q;
			end
			ST_BIND: begin
				if (out_free) begin
					map_we         = 1'b1;
					map_wdata      = {1'b1, best_idx_q};
					bt_wr.en       = 1'b1;
					bt_wr.owner_en = 1'b1;
					bt_wr.idx      = best_idx_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		if (accept) begin
			map_rd_q <= map_mem[s_tdata[CLU_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cluster_q <= s_tdata[CLU_W-1:0];
		end
		if (state_q == ST_SCAN && cmp_valid_q && take_best) begin
			best_idx_q   <= cmp_idx_q;
			best_stamp_q <= bt_rd.stamp;
			best_owner_q <= bt_rd.owner;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			scan_q      <= '0;
			cmp_valid_q <= 1'b0;
			cmp_idx_q   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLU_W'(1);
					if (clr_q == CLU_W'(NUM_CLUSTERS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (!hit && !bt_free.found) begin
						scan_q      <= '0;
						cmp_valid_q <= 1'b0;
						state_q     <= ST_SCAN;
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {CLU_W'(0), 1'b0, !hit,
							hit ? map_rd_q[BLK_W-1:0] : bt_free.idx};
						count_q    <= count_q + STAMP_W'(1);
						state_q    <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// Issue one table read a cycle; compare the entry read last cycle
					if (scan_q < usable) begin
						scan_q      <= scan_q + CNT_W'(1);
						cmp_valid_q <= 1'b1;
						cmp_idx_q   <= scan_q[BLK_W-1:0];
					end else begin
						cmp_valid_q <= 1'b0;
					end
					if (cmp_valid_q && cmp_idx_q == last_idx) begin
						cmp_valid_q <= 1'b0;
						state_q     <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					state_q <= ST_BIND;
				end
				ST_BIND: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {best_owner_q, 1'b1, 1'b1, best_idx_q};
						count_q    <= count_q + STAMP_W'(1);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/cclm_checker.sv]
// ----------------------------------------------------------------------------
// cclm_checker
// Port-level checks on the cluster cache LRU map, bound to the top level.
// ----------------------------------------------------------------------------
module cclm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cclm_pkg::OUT_DATA_W-1:0] m_tdata
);
	import cclm_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One request in flight: drop ready after taking a request
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another in flight");

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[BLK_W] |-> !m_tdata[BLK_W+1])
		else $error("eviction reported on a hit");

	// Evicted cluster reads zero when nothing was evicted
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[BLK_W+1] |-> m_tdata[OUT_DATA_W-1:BLK_W+2] == '0)
		else $error("evicted cluster set without an eviction");

endmodule

bind cluster_cache_lru_map cclm_checker u_cclm_checker (.*);
